FILE: hdl/etp_pkg.sv
// Edge-period tachometer package: widths, edge codes, sequencer states.
// No dependencies; imported by edge_period_tachometer_top.
`timescale 1ns / 1ps

package etp_pkg;

    localparam int TOP_ENTRIES = 3;   // depth of the descending rate list
    localparam int SHOWN_ENTRIES = 3; // list entries carried on the result item
    localparam int NUM_W = 36;        // numerator width
    localparam int RATE_W = 32;       // rpm and period width
    localparam int TS_W = 64;         // timestamps and counters
    localparam int DIV_STEPS = NUM_W; // one quotient bit per cycle
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int OUT_W = 4 * RATE_W + 4 * TS_W;

    localparam logic [NUM_W-1:0] NUMERATOR_RESET = 36'd60000000000;

    localparam logic [1:0] KIND_RISE = 2'd0;
    localparam logic [1:0] KIND_FALL = 2'd1;

    typedef logic [RATE_W-1:0] t_rate;
    typedef logic [TS_W-1:0] t_count;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/edge_period_tachometer_top.sv
// Edge-period tachometer: edge period to rpm via a bit-serial divider.
// A falling edge with a nonzero period goes through ST_DIV (36 divider
// steps, one per quotient bit) and ST_DONE to the output register; other
// items go through ST_DONE only; no new item is taken until the last result
// is loaded. Reset is synchronous, active low; it clears the control state,
// counters and list, not divider or output data, and loads the default numerator.
`timescale 1ns / 1ps

module edge_period_tachometer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: rpm_numerator
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [etp_pkg::NUM_W-1:0]    i_cfg_data,
    // input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [etp_pkg::TS_W-1:0]     s_axis_tdata,  // event time
    input  logic [1:0]                   s_axis_tuser,  // edge_kind
    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // rpm_value, top_first, top_second, top_third, rising_total,
    // falling_total, other_total, span_ns
    output logic [etp_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                         m_axis_tuser   // rpm_updated
);
    import etp_pkg::*;

    t_state r_state, n_state;

    logic [NUM_W-1:0]  r_numerator;
    t_count            r_period_start;
    t_count            r_last_fall;
    t_rate             r_rpm;
    t_rate             r_top [TOP_ENTRIES];
    t_count            r_rise_cnt;
    t_count            r_fall_cnt;
    t_count            r_other_cnt;
    logic              r_updated;

    // divider: r_quo shifts numerator bits out and quotient bits in
    logic [NUM_W-1:0]  r_quo;
    t_rate             r_rem;
    t_rate             r_div;
    logic [CNT_W-1:0]  r_cnt;

    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_upd;
    logic              r_out_valid;

    logic              in_accept;
    logic              out_load;
    logic              div_start;
    t_rate             period;
    logic [RATE_W:0]   trial;
    logic [RATE_W+1:0] diff;
    logic              ge;
    t_rate             rpm_sat;
    t_rate             rpm_new;
    logic              gt [TOP_ENTRIES];
    t_rate             top_ins [TOP_ENTRIES];
    t_rate             top_new [TOP_ENTRIES];
    t_rate             top_shown [SHOWN_ENTRIES];

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_upd;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign period    = s_axis_tdata[RATE_W-1:0] - r_period_start[RATE_W-1:0];
    assign div_start = in_accept && (s_axis_tuser == KIND_FALL) && (period != '0);

    // shared subtractor: one restoring step per cycle
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_div};
    assign ge    = !diff[RATE_W+1];

    assign rpm_sat = (|r_quo[NUM_W-1:RATE_W]) ? '1 : r_quo[RATE_W-1:0];
    assign rpm_new = r_updated ? rpm_sat : r_rpm;

    // list stays descending, so gt is monotone: insert at the first set bit
    always_comb begin
        for (int k = 0; k < TOP_ENTRIES; k++) begin
            gt[k] = rpm_sat > r_top[k];
        end
        top_ins[0] = gt[0] ? rpm_sat : r_top[0];
        for (int k = 1; k < TOP_ENTRIES; k++) begin
            if (!gt[k]) begin
                top_ins[k] = r_top[k];
            end else if (!gt[k-1]) begin
                top_ins[k] = rpm_sat;
            end else begin
                top_ins[k] = r_top[k-1];
            end
        end
        for (int k = 0; k < TOP_ENTRIES; k++) begin
            top_new[k] = r_updated ? top_ins[k] : r_top[k];
        end
    end

    // entries past the list depth read as zero
    for (genvar g = 0; g < SHOWN_ENTRIES; g++) begin : g_shown
        if (g < TOP_ENTRIES) begin : g_have
            assign top_shown[g] = top_new[g];
        end else begin : g_none
            assign top_shown[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_accept) begin
                    n_state = div_start ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator    <= NUMERATOR_RESET;
            r_period_start <= '0;
            r_last_fall    <= '0;
            r_rpm          <= '0;
            r_rise_cnt     <= '0;
            r_fall_cnt     <= '0;
            r_other_cnt    <= '0;
            r_updated      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cnt          <= '0;
            for (int k = 0; k < TOP_ENTRIES; k++) begin
                r_top[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_numerator <= i_cfg_data;
            end

            if (in_accept) begin
                r_updated <= div_start;
                case (s_axis_tuser)
                    KIND_RISE: begin
                        r_period_start <= r_last_fall;
                        r_rise_cnt     <= r_rise_cnt + 1'b1;
                    end
                    KIND_FALL: begin
                        r_last_fall <= s_axis_tdata;
                        r_fall_cnt  <= r_fall_cnt + 1'b1;
                    end
                    default: r_other_cnt <= r_other_cnt + 1'b1;
                endcase
            end

            if (div_start) begin
                r_quo <= r_numerator;
                r_rem <= '0;
                r_div <= period;
                r_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_rem <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end

            // commit rpm and list together with the result item
            if (out_load) begin
                r_rpm <= rpm_new;
                for (int k = 0; k < TOP_ENTRIES; k++) begin
                    r_top[k] <= top_new[k];
                end
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_upd  <= r_updated;
            r_out_data <= {r_last_fall - r_period_start, r_other_cnt, r_fall_cnt,
                           r_rise_cnt, top_shown[2], top_shown[1], top_shown[0],
                           rpm_new};
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // divider never runs on a zero period
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div != '0))
        else $error("divider running with zero divisor");

    // a new result only appears from the result-load state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result valid without a load");

    for (genvar g = 1; g < TOP_ENTRIES; g++) begin : g_chk_order
        a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_top[g-1] >= r_top[g])
            else $error("rate list out of order");
    end
`endif

endmodule

FILE: tb/sv/edge_period_tachometer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for edge_period_tachometer_top: streams edge items,
// predicts every rpm, top-list, counter and span result and compares them.
// Depends on etp_pkg and edge_period_tachometer_top.

module edge_period_tachometer_top_tb;
    import etp_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 50;
    localparam int MAX_REPORTED = 10;
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_UNDEF = 2'd3;
    localparam logic [NUM_W-1:0] NUMERATOR_MAX = '1;

    typedef struct {
        t_rate  rpm;
        logic   updated;
        t_rate  top [SHOWN_ENTRIES];
        t_count rising;
        t_count falling;
        t_count other;
        t_count span;
    } t_tach_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [NUM_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TS_W-1:0]    s_axis_tdata = '0;   // event time
    logic [1:0]         s_axis_tuser = '0;   // edge_kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // rpm_value, top_first, top_second, top_third, rising_total,
    // falling_total, other_total, span_ns
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tuser;        // rpm_updated

    // predictor state
    logic [NUM_W-1:0]   mdl_numerator;
    t_count             mdl_start;
    t_count             mdl_last_fall;
    t_rate              mdl_rpm;
    t_rate              mdl_top [TOP_ENTRIES];
    t_count             mdl_rising;
    t_count             mdl_falling;
    t_count             mdl_other;

    t_tach_report       expected_reports [$];
    int                 fail_count = 0;
    int                 items_sent = 0;
    int                 rpm_updates = 0;
    int                 results_seen = 0;
    int                 numerator_loads = 0;
    bit                 gaps_on = 1'b1;
    bit                 stalls_on = 1'b1;

    edge_period_tachometer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTED) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            note_failure($sformatf("result %0d %s: expected %h, actual %h",
                                   results_seen, name, want, got));
        end
    endfunction

    // Apply one edge to the predicted state and build the result it causes.
    function automatic t_tach_report advance_tach(input logic [1:0] kind, input t_count ts);
        t_tach_report rep;
        logic [RATE_W-1:0] period;
        logic [63:0] quotient;
        bit placed;
        rep.updated = 1'b0;
        case (kind)
            KIND_RISE: begin
                mdl_start = mdl_last_fall;
                mdl_rising++;
            end
            KIND_FALL: begin
                mdl_last_fall = ts;
                mdl_falling++;
                period = RATE_W'(mdl_last_fall - mdl_start);
                if (period != '0) begin
                    quotient = 64'(mdl_numerator) / 64'(period);
                    mdl_rpm = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[RATE_W-1:0];
                    // shift lower entries down; equal values land below
                    placed = 1'b0;
                    for (int pos = 0; pos < TOP_ENTRIES; pos++) begin
                        if (!placed && mdl_rpm > mdl_top[pos]) begin
                            for (int k = TOP_ENTRIES - 1; k > pos; k--) begin
                                mdl_top[k] = mdl_top[k-1];
                            end
                            mdl_top[pos] = mdl_rpm;
                            placed = 1'b1;
                        end
                    end
                    rep.updated = 1'b1;
                end
            end
            default: begin
                mdl_other++;
            end
        endcase
        rep.rpm = mdl_rpm;
        for (int i = 0; i < SHOWN_ENTRIES; i++) begin
            rep.top[i] = (i < TOP_ENTRIES) ? mdl_top[i] : '0;
        end
        rep.rising = mdl_rising;
        rep.falling = mdl_falling;
        rep.other = mdl_other;
        rep.span = mdl_last_fall - mdl_start;
        return rep;
    endfunction

    function automatic t_count random_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [RATE_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return $urandom_range(1, 20);
            3, 4, 5: return $urandom_range(21, 5000);
            6, 7:    return $urandom_range(5001, 10_000_000);
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high on return so a following item goes out back to back;
    // callers that advance time otherwise go through drain_results.
    task automatic send_edge(input logic [1:0] kind, input t_count ts);
        t_tach_report rep;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= ts;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rep = advance_tach(kind, ts);
        expected_reports.push_back(rep);
        items_sent++;
        if (rep.updated) begin
            rpm_updates++;
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_numerator(input logic [NUM_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mdl_numerator = value;
        numerator_loads++;
    endtask

    // One rise followed by a few falls measured from the new period start.
    task automatic send_revolution(inout int sent);
        t_count ts;
        send_edge(KIND_RISE, random_stamp());
        sent++;
        repeat ($urandom_range(1, 3)) begin
            ts = mdl_start + t_count'(pick_period());
            if ($urandom_range(0, 3) == 0) begin
                ts += {$urandom, 32'h0};
            end
            send_edge(KIND_FALL, ts);
            sent++;
        end
    endtask

    task automatic run_random_phase(input int count, input bit idle_allowed);
        int sent;
        sent = 0;
        gaps_on = idle_allowed;
        stalls_on = idle_allowed;
        while (sent < count) begin
            if (idle_allowed && $urandom_range(0, 30) == 0) begin
                gaps_on = !gaps_on;
            end
            if (idle_allowed && $urandom_range(0, 30) == 0) begin
                stalls_on = !stalls_on;
            end
            if ($urandom_range(0, 9) < 7) begin
                send_revolution(sent);
            end else begin
                send_edge(2'($urandom_range(0, 3)), random_stamp());
                sent++;
            end
        end
    endtask

    task automatic test_event_kinds();
        send_edge(KIND_OTHER, random_stamp());
        send_edge(KIND_UNDEF, random_stamp());
        send_edge(KIND_RISE, '0);
        send_edge(KIND_FALL, '0);                           // zero period
        send_edge(KIND_FALL, '1);                           // longest period
        send_edge(KIND_RISE, '0);
        send_edge(KIND_FALL, mdl_start + 64'h1_0000_0000);  // low word wraps to zero
    endtask

    task automatic test_rate_ranking();
        send_edge(KIND_RISE, random_stamp());
        send_edge(KIND_FALL, mdl_start + 64'd100_000_000);
        send_edge(KIND_FALL, mdl_start + 64'd100_000_000);  // equal rate goes below
        send_edge(KIND_FALL, mdl_start + 64'd50_000_000);   // new top, shift down
        send_edge(KIND_FALL, mdl_start + 64'd200_000_000);  // below whole list
        send_edge(KIND_FALL, mdl_start + 64'hFFFF_FFFF);
    endtask

    task automatic test_low_numerators();
        load_numerator(NUM_W'(1));
        run_random_phase(150, 1'b1);
        load_numerator(NUM_W'($urandom_range(2, 1_000_000)));
        run_random_phase(300, 1'b1);
    endtask

    task automatic test_default_numerator();
        load_numerator(NUMERATOR_RESET);
        run_random_phase(150, 1'b1);
        // hold off until every result is back, then resume
        drain_results();
        run_random_phase(150, 1'b1);
    endtask

    task automatic test_wide_numerators();
        load_numerator({4'($urandom_range(0, 15)), 32'($urandom)});
        run_random_phase(300, 1'b1);
    endtask

    task automatic test_numerator_extremes();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        load_numerator('0);
        send_edge(KIND_RISE, random_stamp());
        send_edge(KIND_FALL, mdl_start + 64'd1000);
        load_numerator(NUM_W'(1));
        send_edge(KIND_RISE, random_stamp());
        send_edge(KIND_FALL, mdl_start + 64'd1);
        send_edge(KIND_FALL, mdl_start + 64'd2);
        load_numerator(NUMERATOR_MAX);
        send_edge(KIND_RISE, random_stamp());
        send_edge(KIND_FALL, mdl_start + 64'd16);           // just fits 32 bits
        send_edge(KIND_FALL, mdl_start + 64'd15);           // saturates
        send_edge(KIND_FALL, mdl_start + 64'd1);
    endtask

    task automatic test_saturated_rates();
        run_random_phase(300, 1'b1);
    endtask

    task automatic test_back_to_back();
        load_numerator({4'($urandom_range(0, 15)), 32'($urandom)});
        run_random_phase(250, 1'b0);
    endtask

    initial begin : result_stalls
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tach_report got;
        t_tach_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.rpm = m_axis_tdata[0 +: RATE_W];
            got.updated = m_axis_tuser;
            for (int i = 0; i < SHOWN_ENTRIES; i++) begin
                got.top[i] = m_axis_tdata[RATE_W*(i+1) +: RATE_W];
            end
            got.rising = m_axis_tdata[RATE_W*(SHOWN_ENTRIES+1) +: TS_W];
            got.falling = m_axis_tdata[RATE_W*(SHOWN_ENTRIES+1) + TS_W +: TS_W];
            got.other = m_axis_tdata[RATE_W*(SHOWN_ENTRIES+1) + 2*TS_W +: TS_W];
            got.span = m_axis_tdata[RATE_W*(SHOWN_ENTRIES+1) + 3*TS_W +: TS_W];
            if (expected_reports.size() == 0) begin
                note_failure($sformatf("result %0d arrived with nothing expected",
                                       results_seen));
            end else begin
                want = expected_reports.pop_front();
                check_field("rpm_value", want.rpm, got.rpm);
                check_field("rpm_updated", want.updated, got.updated);
                for (int i = 0; i < SHOWN_ENTRIES; i++) begin
                    check_field($sformatf("top[%0d]", i), want.top[i], got.top[i]);
                end
                check_field("rising_total", want.rising, got.rising);
                check_field("falling_total", want.falling, got.falling);
                check_field("other_total", want.other, got.other);
                check_field("span_ns", want.span, got.span);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still pending",
                 cycles, expected_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mdl_numerator = NUMERATOR_RESET;
        mdl_start = '0;
        mdl_last_fall = '0;
        mdl_rpm = '0;
        mdl_rising = '0;
        mdl_falling = '0;
        mdl_other = '0;
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            mdl_top[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_event_kinds();
        test_rate_ranking();
        test_low_numerators();
        test_default_numerator();
        test_wide_numerators();
        test_numerator_extremes();
        test_saturated_rates();
        test_back_to_back();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_reports.size()));
        end

        $display("Summary: %0d edge items (%0d rising, %0d falling, %0d other or undefined),",
                 items_sent, mdl_rising, mdl_falling, mdl_other);
        $display("         %0d rpm updates over %0d numerator settings, %0d results, %0d failures",
                 rpm_updates, numerator_loads, results_seen, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
